// ===== rtl/iprs_pkg.sv =====
// Shared types, constants and helpers for the image packet reassembler.
// No dependencies; used by iprs_ctrl, iprs_dpath and the top level.
package iprs_pkg;

    // Sizes
    localparam int IMAGE_SIZE_BYTES = 3813;
    localparam int STAGE_DEPTH      = 256;
    localparam int POS_MAX          = 511;
    localparam int RECV_MAX         = 131071;

    localparam int IMG_AW = (IMAGE_SIZE_BYTES > 1) ? $clog2(IMAGE_SIZE_BYTES) : 1;
    localparam int STG_AW = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;
    // walk counter covers both the store clear and the payload copy
    localparam int WK_W   = ($clog2(IMAGE_SIZE_BYTES + 1) > 10) ?
                            $clog2(IMAGE_SIZE_BYTES + 1) : 10;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 4;

    typedef logic [IMG_AW-1:0] img_addr_t;
    typedef logic [STG_AW-1:0] stg_addr_t;
    typedef logic [WK_W-1:0]   walk_t;
    typedef logic [8:0]        pos_t;
    typedef logic [16:0]       rcv_t;
    typedef logic [15:0]       word16_t;
    typedef logic [3:0]        status_t;

    // Input operation select
    localparam logic OPER_PACKET = 1'b0;
    localparam logic OPER_READ   = 1'b1;

    // Packet opcodes
    localparam logic [7:0] OP_TIME_LIMIT = 8'h80;
    localparam logic [7:0] OP_START      = 8'h80;
    localparam logic [7:0] OP_DATA       = 8'h81;
    localparam logic [7:0] OP_END        = 8'h82;

    // Result status codes
    localparam status_t ST_TIME        = 4'd0;
    localparam status_t ST_START       = 4'd1;
    localparam status_t ST_START_SHORT = 4'd2;
    localparam status_t ST_STORED      = 4'd3;
    localparam status_t ST_DATA_SHORT  = 4'd4;
    localparam status_t ST_OVERFLOW    = 4'd5;
    localparam status_t ST_END_OK      = 4'd6;
    localparam status_t ST_MISMATCH    = 4'd7;
    localparam status_t ST_UNKNOWN     = 4'd8;
    localparam status_t ST_READ        = 4'd9;

    // Controller -> datapath commands
    typedef struct packed {
        logic accept;       // input word taken this cycle
        logic read_done;    // store read data valid, build read result
        logic out_load;     // move pending result into output register
        logic walk_init;    // zero the walk counter
        logic clear_step;   // write one zero into the store
        logic copy_step;    // move one staged byte
    } dp_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic pend_clear;
        logic pend_copy;
        logic clear_last;
        logic copy_last;
    } dp_stat_t;

    // hours (bits 6..2) * 100 + quarters (bits 1..0) * 25
    function automatic logic [11:0] time_decode(input logic [7:0] op);
        logic [11:0] hrs;
        logic [11:0] qtr;
        hrs = 12'(op[6:2] & 5'h1F);
        qtr = 12'(op[1:0] & 2'h3);
        return hrs * 12'd100 + qtr * 12'd25;
    endfunction

endpackage

// ===== rtl/iprs_ctrl.sv =====
// Control FSM of the image packet reassembler: handshakes, store clear
// and payload copy sequencing. Depends on iprs_pkg.
module iprs_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_oper,
    input  logic               s_last,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  iprs_pkg::dp_stat_t stat,
    output iprs_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_COPY  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.accept = accept;
                if (accept)
                begin
                    if (s_oper == iprs_pkg::OPER_READ)
                    begin
                        state_next = S_READ;
                    end
                    else if (s_last)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_READ:
            begin
                cmd.read_done = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.walk_init = 1'b1;
                    if (stat.pend_clear)
                    begin
                        state_next = S_CLEAR;
                    end
                    else if (stat.pend_copy)
                    begin
                        state_next = S_COPY;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (stat.copy_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last copy write lands here
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result loaded over an untaken word");

    // clear walk runs to its last entry
    a_clear_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && !stat.clear_last) |=> (state_reg == S_CLEAR))
        else $error("store clear left early");

    // a taken store read passes through S_READ before it reaches S_EMIT
    a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && s_oper == iprs_pkg::OPER_READ) |=> ##1 (state_reg == S_EMIT))
        else $error("read result not staged in time");

endmodule

// ===== rtl/iprs_dpath.sv =====
// Datapath of the image packet reassembler: packet state, payload stage,
// image store, result and output registers. Depends on iprs_pkg.
module iprs_dpath
(
    input  logic                clk,
    input  logic                rst_n,
    input  iprs_pkg::dp_cmd_t   cmd,
    output iprs_pkg::dp_stat_t  stat,
    input  logic                operation,
    input  logic [7:0]          packet_byte,
    input  logic                first_of_packet,
    input  logic                last_of_packet,
    input  logic [11:0]         read_address,
    output iprs_pkg::status_t   status,
    output logic [11:0]         time_hundredths,
    output logic [7:0]          read_data,
    output iprs_pkg::rcv_t      bytes_received,
    output iprs_pkg::word16_t   bytes_expected
);

    // memories
    logic [7:0] store_mem [iprs_pkg::IMAGE_SIZE_BYTES];
    logic [7:0] stage_mem [iprs_pkg::STAGE_DEPTH];

    // control state
    iprs_pkg::pos_t    pos_reg,    pos_next;
    logic [7:0]        opcode_reg, opcode_next;
    iprs_pkg::word16_t header_reg, header_next;
    iprs_pkg::rcv_t    rcv_reg,    rcv_next;
    iprs_pkg::word16_t exp_reg,    exp_next;
    iprs_pkg::walk_t   cnt_reg,    cnt_next;
    logic              cp_wr_reg;
    logic              pend_clear_reg, pend_clear_next;
    logic              pend_copy_reg,  pend_copy_next;

    // payload registers
    iprs_pkg::img_addr_t copy_off_reg;
    iprs_pkg::pos_t      copy_len_reg;
    iprs_pkg::img_addr_t cp_addr_reg;
    logic [7:0]          st_rd_reg;
    logic [7:0]          stg_rd_reg;
    logic                rd_ok_reg;
    iprs_pkg::status_t   res_status_reg, res_status_next;
    logic [11:0]         res_time_reg,   res_time_next;
    logic [7:0]          res_rdata_reg,  res_rdata_next;
    iprs_pkg::rcv_t      res_rcv_reg,    res_rcv_next;
    iprs_pkg::word16_t   res_exp_reg,    res_exp_next;
    iprs_pkg::status_t   out_status_reg;
    logic [11:0]         out_time_reg;
    logic [7:0]          out_rdata_reg;
    iprs_pkg::rcv_t      out_rcv_reg;
    iprs_pkg::word16_t   out_exp_reg;

    // byte step
    logic              byte_acc;
    logic              read_acc;
    logic              close;
    iprs_pkg::pos_t    idx;
    iprs_pkg::pos_t    sidx;
    iprs_pkg::pos_t    count;
    iprs_pkg::pos_t    len;
    logic [7:0]        op_now;
    iprs_pkg::word16_t hdr_now;
    logic              stg_we;
    logic [16:0]       fit_sum;
    logic [17:0]       sat_sum;
    iprs_pkg::rcv_t    rcv_sat;
    logic              overflow;
    logic              rd_in_range;

    // store port
    logic                st_we;
    iprs_pkg::img_addr_t st_wa;
    logic [7:0]          st_wd;

    assign byte_acc    = cmd.accept && (operation == iprs_pkg::OPER_PACKET);
    assign read_acc    = cmd.accept && (operation == iprs_pkg::OPER_READ);
    assign close       = byte_acc && last_of_packet;
    assign idx         = first_of_packet ? '0 : pos_reg;
    assign sidx        = idx - 9'd3;
    assign stg_we      = byte_acc && (idx >= 9'd3) &&
                         (10'(sidx) < 10'(iprs_pkg::STAGE_DEPTH));
    assign count       = (idx < 9'(iprs_pkg::POS_MAX)) ? idx + 9'd1 : 9'(iprs_pkg::POS_MAX);
    assign len         = count - 9'd3;
    assign op_now      = (idx == '0) ? packet_byte : opcode_reg;
    assign fit_sum     = 17'(hdr_now) + 17'(len);
    assign sat_sum     = 18'(rcv_reg) + 18'(len);
    assign rcv_sat     = (sat_sum > 18'(iprs_pkg::RECV_MAX)) ?
                         17'(iprs_pkg::RECV_MAX) : sat_sum[16:0];
    assign overflow    = (count == 9'(iprs_pkg::POS_MAX)) ||
                         (10'(len) > 10'(iprs_pkg::STAGE_DEPTH)) ||
                         (fit_sum > 17'(iprs_pkg::IMAGE_SIZE_BYTES));
    assign rd_in_range = (32'(read_address) < iprs_pkg::IMAGE_SIZE_BYTES);

    always_comb
    begin
        if (idx == '0)
        begin
            hdr_now = '0;
        end
        else if (idx <= 9'd2)
        begin
            hdr_now = {header_reg[7:0], packet_byte};
        end
        else
        begin
            hdr_now = header_reg;
        end
    end

    // packet state and close decode
    always_comb
    begin
        pos_next        = pos_reg;
        opcode_next     = opcode_reg;
        header_next     = header_reg;
        rcv_next        = rcv_reg;
        exp_next        = exp_reg;
        pend_clear_next = pend_clear_reg;
        pend_copy_next  = pend_copy_reg;
        res_status_next = res_status_reg;
        res_time_next   = res_time_reg;
        res_rdata_next  = res_rdata_reg;
        res_rcv_next    = res_rcv_reg;
        res_exp_next    = res_exp_reg;

        if (read_acc)
        begin
            pend_clear_next = 1'b0;
            pend_copy_next  = 1'b0;
        end

        if (cmd.read_done)
        begin
            res_status_next = iprs_pkg::ST_READ;
            res_time_next   = '0;
            res_rdata_next  = rd_ok_reg ? st_rd_reg : 8'h00;
            res_rcv_next    = rcv_reg;
            res_exp_next    = exp_reg;
        end

        if (byte_acc)
        begin
            opcode_next     = op_now;
            header_next     = hdr_now;
            pos_next        = last_of_packet ? '0 : count;
            pend_clear_next = 1'b0;
            pend_copy_next  = 1'b0;
        end

        if (close)
        begin
            res_time_next  = '0;
            res_rdata_next = '0;
            if (op_now < iprs_pkg::OP_TIME_LIMIT)
            begin
                res_status_next = iprs_pkg::ST_TIME;
                res_time_next   = iprs_pkg::time_decode(op_now);
            end
            else if (op_now == iprs_pkg::OP_START)
            begin
                if (count < 9'd3)
                begin
                    res_status_next = iprs_pkg::ST_START_SHORT;
                end
                else
                begin
                    res_status_next = iprs_pkg::ST_START;
                    exp_next        = hdr_now;
                    rcv_next        = '0;
                    pend_clear_next = 1'b1;
                end
            end
            else if (op_now == iprs_pkg::OP_DATA)
            begin
                if (count < 9'd4)
                begin
                    res_status_next = iprs_pkg::ST_DATA_SHORT;
                end
                else if (overflow)
                begin
                    res_status_next = iprs_pkg::ST_OVERFLOW;
                end
                else
                begin
                    res_status_next = iprs_pkg::ST_STORED;
                    rcv_next        = rcv_sat;
                    pend_copy_next  = 1'b1;
                end
            end
            else if (op_now == iprs_pkg::OP_END)
            begin
                res_status_next = (rcv_reg == 17'(exp_reg) && exp_reg != '0) ?
                                  iprs_pkg::ST_END_OK : iprs_pkg::ST_MISMATCH;
            end
            else
            begin
                res_status_next = iprs_pkg::ST_UNKNOWN;
            end
            res_rcv_next = rcv_next;
            res_exp_next = exp_next;
        end
    end

    // walk counter
    always_comb
    begin
        if (cmd.walk_init)
        begin
            cnt_next = '0;
        end
        else if (cmd.clear_step || cmd.copy_step)
        begin
            cnt_next = cnt_reg + iprs_pkg::walk_t'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    assign stat.pend_clear = pend_clear_reg;
    assign stat.pend_copy  = pend_copy_reg;
    assign stat.clear_last = (cnt_reg == iprs_pkg::walk_t'(iprs_pkg::IMAGE_SIZE_BYTES - 1));
    assign stat.copy_last  = (cnt_reg == iprs_pkg::walk_t'(copy_len_reg) - iprs_pkg::walk_t'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            opcode_reg     <= '0;
            header_reg     <= '0;
            rcv_reg        <= '0;
            exp_reg        <= '0;
            cnt_reg        <= '0;
            cp_wr_reg      <= 1'b0;
            pend_clear_reg <= 1'b0;
            pend_copy_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            opcode_reg     <= opcode_next;
            header_reg     <= header_next;
            rcv_reg        <= rcv_next;
            exp_reg        <= exp_next;
            cnt_reg        <= cnt_next;
            cp_wr_reg      <= cmd.copy_step;
            pend_clear_reg <= pend_clear_next;
            pend_copy_reg  <= pend_copy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_time_reg   <= res_time_next;
        res_rdata_reg  <= res_rdata_next;
        res_rcv_reg    <= res_rcv_next;
        res_exp_reg    <= res_exp_next;
        if (close)
        begin
            copy_off_reg <= iprs_pkg::img_addr_t'(hdr_now);
            copy_len_reg <= len;
        end
        if (read_acc)
        begin
            rd_ok_reg <= rd_in_range;
        end
        if (cmd.copy_step)
        begin
            cp_addr_reg <= iprs_pkg::img_addr_t'(iprs_pkg::walk_t'(copy_off_reg) + cnt_reg);
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_time_reg   <= res_time_reg;
            out_rdata_reg  <= res_rdata_reg;
            out_rcv_reg    <= res_rcv_reg;
            out_exp_reg    <= res_exp_reg;
        end
    end

    // payload stage: written by the byte step, read by the copy walk
    always_ff @(posedge clk)
    begin
        if (stg_we)
        begin
            stage_mem[iprs_pkg::stg_addr_t'(sidx)] <= packet_byte;
        end
        if (cmd.copy_step)
        begin
            stg_rd_reg <= stage_mem[iprs_pkg::stg_addr_t'(cnt_reg)];
        end
    end

    // image store: clear walk or delayed copy write, one read port
    always_comb
    begin
        if (cmd.clear_step)
        begin
            st_we = 1'b1;
            st_wa = iprs_pkg::img_addr_t'(cnt_reg);
            st_wd = 8'h00;
        end
        else
        begin
            st_we = cp_wr_reg;
            st_wa = cp_addr_reg;
            st_wd = stg_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_wa] <= st_wd;
        end
        if (read_acc && rd_in_range)
        begin
            st_rd_reg <= store_mem[iprs_pkg::img_addr_t'(read_address)];
        end
    end

    assign status          = out_status_reg;
    assign time_hundredths = out_time_reg;
    assign read_data       = out_rdata_reg;
    assign bytes_received  = out_rcv_reg;
    assign bytes_expected  = out_exp_reg;

    // a start packet and a data packet never both leave work behind
    a_one_walk: assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_clear_reg && pend_copy_reg))
        else $error("clear and copy both pending");

    // copy writes stay inside the store
    a_copy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cp_wr_reg |-> (32'(cp_addr_reg) < iprs_pkg::IMAGE_SIZE_BYTES))
        else $error("copy write beyond image store");

endmodule

// ===== rtl/image_packet_reassembler_top.sv =====
// Top level of the image packet reassembler: stream ports, field packing,
// controller and datapath. Depends on iprs_pkg, iprs_ctrl, iprs_dpath.
//
// Packet bytes arrive on the input stream, one per word, with tlast closing a
// packet and a first flag opening one; a read word returns one image store
// byte instead. Every read and every closing byte yields one result word;
// other bytes yield none. A non-closing byte keeps the input ready. A closing
// byte is taken and decoded, then handed to the output register, followed by
// a copy walk over the payload and a drain state for a stored data packet, or
// a clear walk over all IMAGE_SIZE_BYTES (3813) store entries for an accepted
// start packet; those walks run through the single write port of the image
// store, one byte a cycle. A read goes through the registered store read.
// After reset the store is cleared the same way before tready rises. The
// output register lets the next word be taken while a result waits.
module image_packet_reassembler_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] packet_byte, [19:8] read_address, [23:20] zero
    input  logic [iprs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [0] operation, [1] first_of_packet
    input  logic [iprs_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    // last_of_packet
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [11:0] time_hundredths, [19:12] read_data, [36:20] bytes_received,
    // [52:37] bytes_expected, [55:53] zero
    output logic [iprs_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [3:0] status
    output logic [iprs_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

    iprs_pkg::dp_cmd_t  cmd;
    iprs_pkg::dp_stat_t stat;

    // unpacked input fields
    logic        operation;
    logic        first_of_packet;
    logic [7:0]  packet_byte;
    logic [11:0] read_address;

    // result fields
    iprs_pkg::status_t status;
    logic [11:0]       time_hundredths;
    logic [7:0]        read_data;
    iprs_pkg::rcv_t    bytes_received;
    iprs_pkg::word16_t bytes_expected;

    assign operation       = s_axis_tuser[0];
    assign first_of_packet = s_axis_tuser[1];
    assign packet_byte     = s_axis_tdata[7:0];
    assign read_address    = s_axis_tdata[19:8];

    iprs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_oper   (operation),
        .s_last   (s_axis_tlast),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iprs_dpath u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .operation       (operation),
        .packet_byte     (packet_byte),
        .first_of_packet (first_of_packet),
        .last_of_packet  (s_axis_tlast),
        .read_address    (read_address),
        .status          (status),
        .time_hundredths (time_hundredths),
        .read_data       (read_data),
        .bytes_received  (bytes_received),
        .bytes_expected  (bytes_expected)
    );

    // pack result word, lowest field first
    assign m_axis_tdata = {3'b000, bytes_expected, bytes_received, read_data, time_hundredths};
    assign m_axis_tuser = status;

endmodule
